// File: rtl/core/smb_pkg.sv
package smb_pkg;

   // request action codes
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_CLOCK_MODE   = 2'd0;
   localparam logic [1:0] CSR_LSB_FIRST    = 2'd1;
   localparam logic [1:0] CSR_BAUD_DIVISOR = 2'd2;

   localparam logic [7:0] BAUD_DIVISOR_RESET = 8'd255;
   localparam int         BITS_PER_WORD      = 8;
   localparam int         QUEUE_DEPTH        = 2;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] tx_byte;
      logic       miso_bit;
   } smb_cmd_type;

   typedef struct packed {
      logic [1:0] clock_mode;
      logic       lsb_first;
      logic [7:0] baud_divisor;
   } smb_cfg_type;

endpackage

// File: rtl/core/smb_front.sv
module smb_front
   import smb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_miso_bit,
   input  logic        queue_full,
   output logic        push,
   output smb_cmd_type push_cmd
);

   logic        front_valid_ff;
   logic        front_valid_in;
   smb_cmd_type front_cmd_ff;
   smb_cmd_type front_cmd_in;
   logic        accept;

   assign push      = front_valid_ff & ~queue_full;
   assign req_ready = ~front_valid_ff | ~queue_full;
   assign accept    = req_valid & req_ready;
   assign push_cmd  = front_cmd_ff;

   // classify: keep only the operand that the action uses
   always_comb begin
      front_cmd_in.action   = req_action;
      front_cmd_in.tx_byte  = (req_action == ACT_WRITE) ? req_tx_byte : 8'd0;
      front_cmd_in.miso_bit = (req_action == ACT_TICK) ? req_miso_bit : 1'b0;
   end

   always_comb begin
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (push) begin
         front_valid_in = 1'b0;
      end else begin
         front_valid_in = front_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_cmd_ff <= front_cmd_in;
      end
   end

endmodule

// File: rtl/core/smb_queue.sv
module smb_queue
   import smb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  smb_cmd_type push_cmd,
   input  logic        pop,
   output logic        full,
   output logic        not_empty,
   output smb_cmd_type head_cmd
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   smb_cmd_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff;
   logic [PTR_W-1:0]        wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff;
   logic [PTR_W-1:0]        rd_ptr_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/core/smb_back.sv
module smb_back
   import smb_pkg::*;
#(
   parameter int PRESCALE = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  smb_cfg_type cfg,
   input  logic        cmd_valid,
   input  smb_cmd_type cmd,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_sck_level,
   output logic        rsp_mosi_level,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_tx_empty,
   output logic        rsp_transfer_end,
   output logic        rsp_rx_full,
   output logic        rsp_overrun
);

   localparam int HALF_UNIT = PRESCALE / 2;
   localparam int HALF_MAX  = HALF_UNIT * 256;
   localparam int CNT_W     = $clog2(HALF_MAX);
   localparam int HLEN_W    = $clog2(HALF_MAX + 1);

   logic [7:0]        tx_hold_ff,   tx_hold_in;
   logic              hold_full_ff, hold_full_in;
   logic [7:0]        tx_shift_ff,  tx_shift_in;
   logic [7:0]        rx_shift_ff,  rx_shift_in;
   logic [3:0]        bits_left_ff, bits_left_in;
   logic [CNT_W-1:0]  count_ff,     count_in;
   logic              phase_ff,     phase_in;
   logic              busy_ff,      busy_in;
   logic [7:0]        rx_data_ff,   rx_data_in;
   logic              rx_ready_ff,  rx_ready_in;
   logic              overrun_ff,   overrun_in;

   logic              rsp_valid_ff;
   logic              rsp_sck_ff, rsp_mosi_ff, rsp_tx_empty_ff;
   logic              rsp_end_ff, rsp_rx_full_ff, rsp_overrun_ff;
   logic [7:0]        rsp_rx_byte_ff;

   logic [HLEN_W-1:0] half_len;
   logic [HLEN_W-1:0] count_inc;
   logic              cpol;
   logic              cpha;
   logic              sck_in;
   logic              mosi_in;

   assign pop = cmd_valid & (~rsp_valid_ff | rsp_ready);

   assign cpol = cfg.clock_mode[1];
   assign cpha = cfg.clock_mode[0];

   assign half_len  = HLEN_W'(HALF_UNIT) * HLEN_W'({1'b0, cfg.baud_divisor} + 9'd1);
   assign count_inc = HLEN_W'(count_ff) + HLEN_W'(1);

   always_comb begin
      tx_hold_in   = tx_hold_ff;
      hold_full_in = hold_full_ff;
      tx_shift_in  = tx_shift_ff;
      rx_shift_in  = rx_shift_ff;
      bits_left_in = bits_left_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      busy_in      = busy_ff;
      rx_data_in   = rx_data_ff;
      rx_ready_in  = rx_ready_ff;
      overrun_in   = overrun_ff;

      case (cmd.action)
         ACT_TICK: begin
            if (busy_ff) begin
               if (count_inc >= half_len) begin
                  count_in = '0;
                  if (!phase_ff) begin
                     // sample MISO at the end of the first half
                     rx_shift_in = cfg.lsb_first ? {cmd.miso_bit, rx_shift_ff[7:1]}
                                                 : {rx_shift_ff[6:0], cmd.miso_bit};
                     phase_in = 1'b1;
                  end else begin
                     // present the next bit at the end of the second half
                     phase_in     = 1'b0;
                     tx_shift_in  = cfg.lsb_first ? {1'b0, tx_shift_ff[7:1]}
                                                  : {tx_shift_ff[6:0], 1'b0};
                     bits_left_in = bits_left_ff - 4'd1;
                     if (bits_left_ff == 4'd1) begin
                        busy_in = 1'b0;
                        if (rx_ready_ff) begin
                           overrun_in = 1'b1;
                        end else begin
                           rx_data_in  = rx_shift_ff;
                           rx_ready_in = 1'b1;
                        end
                     end
                  end
               end else begin
                  count_in = count_inc[CNT_W-1:0];
               end
            end
            // start the held word once the shifter is free
            if (!busy_in && hold_full_ff) begin
               tx_shift_in  = tx_hold_ff;
               hold_full_in = 1'b0;
               busy_in      = 1'b1;
               bits_left_in = 4'(BITS_PER_WORD);
               count_in     = '0;
               phase_in     = 1'b0;
               rx_shift_in  = 8'd0;
            end
         end
         ACT_WRITE: begin
            tx_hold_in   = cmd.tx_byte;
            hold_full_in = 1'b1;
         end
         ACT_READ: begin
            rx_ready_in = 1'b0;
         end
         ACT_CLEAR: begin
            overrun_in = 1'b0;
         end
         default: begin
            overrun_in = overrun_ff;
         end
      endcase
   end

   always_comb begin
      if (busy_in) begin
         sck_in  = cpol ^ cpha ^ phase_in;
         mosi_in = cfg.lsb_first ? tx_shift_in[0] : tx_shift_in[7];
      end else begin
         sck_in  = cpol;
         mosi_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_hold_ff   <= 8'd0;
         hold_full_ff <= 1'b0;
         tx_shift_ff  <= 8'd0;
         rx_shift_ff  <= 8'd0;
         bits_left_ff <= 4'd0;
         count_ff     <= '0;
         phase_ff     <= 1'b0;
         busy_ff      <= 1'b0;
         rx_data_ff   <= 8'd0;
         rx_ready_ff  <= 1'b0;
         overrun_ff   <= 1'b0;
      end else if (pop) begin
         tx_hold_ff   <= tx_hold_in;
         hold_full_ff <= hold_full_in;
         tx_shift_ff  <= tx_shift_in;
         rx_shift_ff  <= rx_shift_in;
         bits_left_ff <= bits_left_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         busy_ff      <= busy_in;
         rx_data_ff   <= rx_data_in;
         rx_ready_ff  <= rx_ready_in;
         overrun_ff   <= overrun_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_sck_ff      <= sck_in;
         rsp_mosi_ff     <= mosi_in;
         rsp_rx_byte_ff  <= rx_data_in;
         rsp_tx_empty_ff <= ~hold_full_in;
         rsp_end_ff      <= ~busy_in & ~hold_full_in;
         rsp_rx_full_ff  <= rx_ready_in;
         rsp_overrun_ff  <= overrun_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sck_level    = rsp_sck_ff;
   assign rsp_mosi_level   = rsp_mosi_ff;
   assign rsp_rx_byte      = rsp_rx_byte_ff;
   assign rsp_tx_empty     = rsp_tx_empty_ff;
   assign rsp_transfer_end = rsp_end_ff;
   assign rsp_rx_full      = rsp_rx_full_ff;
   assign rsp_overrun      = rsp_overrun_ff;

endmodule

// File: rtl/core/spi_master_byte_shifter.sv
// A request word accepted into the front register passes through the command queue and
//    the executor output register before its response word is valid.
// Throughput: one word per cycle while responses are taken; the executor retires one
//    queued command per cycle and the two-entry queue lets front and executor stall
//    independently. Reset: synchronous, active high; clears all flags, counters and
//    the response valid flag, and loads mode 0, MSB first and baud divisor 255.
module spi_master_byte_shifter
   import smb_pkg::*;
#(
   parameter int PRESCALE = 16
)
(
   input  logic       clock,
   input  logic       reset,

   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [7:0] req_tx_byte,
   input  logic       req_miso_bit,

   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_sck_level,
   output logic       rsp_mosi_level,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_tx_empty,
   output logic       rsp_transfer_end,
   output logic       rsp_rx_full,
   output logic       rsp_overrun,

   // configuration write port
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   smb_cfg_type cfg_ff;
   smb_cfg_type cfg_in;

   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_not_empty;
   smb_cmd_type push_cmd;
   smb_cmd_type head_cmd;

   // Hold the settings; the user must change them only while no word is in flight (the block does not enforce this).
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CLOCK_MODE:   cfg_in.clock_mode   = csr_data[1:0];
            CSR_LSB_FIRST:    cfg_in.lsb_first    = csr_data[0];
            CSR_BAUD_DIVISOR: cfg_in.baud_divisor = csr_data;
            default: begin
               // drop writes to unused indexes
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_mode   <= 2'd0;
         cfg_ff.lsb_first    <= 1'b0;
         cfg_ff.baud_divisor <= BAUD_DIVISOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept and classify request words into commands.
   smb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_tx_byte  (req_tx_byte),
      .req_miso_bit (req_miso_bit),
      .queue_full   (q_full),
      .push         (q_push),
      .push_cmd     (push_cmd)
   );

   // Short command queue between front and executor.
   smb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   // Back: run the shifter, baud timer and flags; register the response word.
   smb_back #(
      .PRESCALE (PRESCALE)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd_valid        (q_not_empty),
      .cmd              (head_cmd),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sck_level    (rsp_sck_level),
      .rsp_mosi_level   (rsp_mosi_level),
      .rsp_rx_byte      (rsp_rx_byte),
      .rsp_tx_empty     (rsp_tx_empty),
      .rsp_transfer_end (rsp_transfer_end),
      .rsp_rx_full      (rsp_rx_full),
      .rsp_overrun      (rsp_overrun)
   );

   // Front must never push into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("command pushed into full queue");

   // Executor retires a command only from a non-empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_not_empty)
      else $error("command popped from empty queue");

   // An idle master with nothing held drives MOSI low and reports the holding register empty.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_transfer_end) |-> (!rsp_mosi_level && rsp_tx_empty))
      else $error("transfer end reported with MOSI high or data held");

endmodule

// File: tb/spi_shifter_checker.sv
`timescale 1ns / 100ps

module spi_shifter_checker
   import smb_pkg::*;
#(
   parameter int PRESCALE = 16
)
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [7:0] req_tx_byte,
   input  logic       req_miso_bit,

   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_sck_level,
   input  logic       rsp_mosi_level,
   input  logic [7:0] rsp_rx_byte,
   input  logic       rsp_tx_empty,
   input  logic       rsp_transfer_end,
   input  logic       rsp_rx_full,
   input  logic       rsp_overrun,

   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data,

   output int         mismatch_count,
   output int         words_pending,
   output int         bytes_shifted
);

   typedef struct packed {
      logic       sck;
      logic       mosi;
      logic [7:0] rx_byte;
      logic       tx_empty;
      logic       xfer_end;
      logic       rx_full;
      logic       overrun;
   } line_status_type;

   line_status_type status_queue[$];

   // shifter settings
   logic [1:0]  cfg_mode;
   logic        cfg_lsb_first;
   logic [7:0]  cfg_divisor;

   // shifter state
   logic [7:0]  hold_byte;
   logic        hold_loaded;
   logic [7:0]  out_shift;
   logic [7:0]  in_shift;
   logic [3:0]  bits_remaining;
   logic [19:0] half_count;
   logic        second_half;
   logic        shifting;
   logic [7:0]  rx_word;
   logic        rx_pending;
   logic        lost_flag;

   int mismatches;
   int pending;
   int shifted_count;

   assign mismatch_count = mismatches;
   assign words_pending  = pending;
   assign bytes_shifted  = shifted_count;

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: mismatch: %s", $time, what);
   endtask

   // advance the shifter by one request word and return the line status after it
   task automatic predict_status(input logic [1:0] act, input logic [7:0] data,
                                 input logic miso, output line_status_type st);
      logic [19:0] half_len;
      logic        cpol;
      logic        cpha;
      half_len = 20'((PRESCALE / 2) * (int'(cfg_divisor) + 1));
      case (act)
         ACT_TICK: begin
            if (shifting) begin
               half_count = half_count + 20'd1;
               if (half_count >= half_len) begin
                  half_count = '0;
                  if (!second_half) begin
                     in_shift    = cfg_lsb_first ? {miso, in_shift[7:1]} : {in_shift[6:0], miso};
                     second_half = 1'b1;
                  end else begin
                     second_half    = 1'b0;
                     out_shift      = cfg_lsb_first ? (out_shift >> 1) : (out_shift << 1);
                     bits_remaining = bits_remaining - 4'd1;
                     if (bits_remaining == 4'd0) begin
                        shifting = 1'b0;
                        shifted_count++;
                        if (rx_pending) begin
                           lost_flag = 1'b1;
                        end else begin
                           rx_word    = in_shift;
                           rx_pending = 1'b1;
                        end
                     end
                  end
               end
            end
            if (!shifting && hold_loaded) begin
               out_shift      = hold_byte;
               hold_loaded    = 1'b0;
               shifting       = 1'b1;
               bits_remaining = 4'(BITS_PER_WORD);
               half_count     = '0;
               second_half    = 1'b0;
               in_shift       = '0;
            end
         end
         ACT_WRITE: begin
            hold_byte   = data;
            hold_loaded = 1'b1;
         end
         ACT_READ: rx_pending = 1'b0;
         default:  lost_flag  = 1'b0;
      endcase

      cpol        = cfg_mode[1];
      cpha        = cfg_mode[0];
      st.sck      = shifting ? (cpol ^ cpha ^ second_half) : cpol;
      st.mosi     = shifting ? (cfg_lsb_first ? out_shift[0] : out_shift[7]) : 1'b0;
      st.rx_byte  = rx_word;
      st.tx_empty = !hold_loaded;
      st.xfer_end = !shifting && !hold_loaded;
      st.rx_full  = rx_pending;
      st.overrun  = lost_flag;
   endtask

   task automatic compare_status(input line_status_type want, input line_status_type got);
      if (got.sck !== want.sck)
         note_mismatch($sformatf("sck_level expected %b got %b", want.sck, got.sck));
      if (got.mosi !== want.mosi)
         note_mismatch($sformatf("mosi_level expected %b got %b", want.mosi, got.mosi));
      if (got.rx_byte !== want.rx_byte)
         note_mismatch($sformatf("rx_byte expected %h got %h", want.rx_byte, got.rx_byte));
      if (got.tx_empty !== want.tx_empty)
         note_mismatch($sformatf("tx_empty expected %b got %b", want.tx_empty, got.tx_empty));
      if (got.xfer_end !== want.xfer_end)
         note_mismatch($sformatf("transfer_end expected %b got %b", want.xfer_end, got.xfer_end));
      if (got.rx_full !== want.rx_full)
         note_mismatch($sformatf("rx_full expected %b got %b", want.rx_full, got.rx_full));
      if (got.overrun !== want.overrun)
         note_mismatch($sformatf("overrun expected %b got %b", want.overrun, got.overrun));
   endtask

   initial begin
      mismatches    = 0;
      pending       = 0;
      shifted_count = 0;
   end

   always @(posedge clock) begin : watch
      line_status_type want;
      line_status_type got;
      if (reset) begin
         cfg_mode       = 2'd0;
         cfg_lsb_first  = 1'b0;
         cfg_divisor    = BAUD_DIVISOR_RESET;
         hold_byte      = '0;
         hold_loaded    = 1'b0;
         out_shift      = '0;
         in_shift       = '0;
         bits_remaining = '0;
         half_count     = '0;
         second_half    = 1'b0;
         shifting       = 1'b0;
         rx_word        = '0;
         rx_pending     = 1'b0;
         lost_flag      = 1'b0;
         status_queue.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CLOCK_MODE:   cfg_mode      = csr_data[1:0];
               CSR_LSB_FIRST:    cfg_lsb_first = csr_data[0];
               CSR_BAUD_DIVISOR: cfg_divisor   = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_status(req_action, req_tx_byte, req_miso_bit, want);
            status_queue.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_sck_level, rsp_mosi_level, rsp_rx_byte, rsp_tx_empty,
                   rsp_transfer_end, rsp_rx_full, rsp_overrun};
            if (status_queue.size() == 0) begin
               note_mismatch("response word with no request word waiting");
            end else begin
               want = status_queue.pop_front();
               compare_status(want, got);
            end
         end
      end
      pending = status_queue.size();
   end

endmodule

// File: tb/spi_master_byte_shifter_tb.sv
`timescale 1ns / 100ps

module spi_master_byte_shifter_tb;
   import smb_pkg::*;

   localparam int SPI_PRESCALE    = 16;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RSP_HOLD_CYCLES = 300;
   // slack after the last response word is back, before the settings change
   localparam int DRAIN_CYCLES    = 4;
   localparam int TAIL_CYCLES     = 20;
   localparam int SLOW_TICKS      = 40;

   localparam logic [1:0] SPI_MODE_0 = 2'd0;
   localparam logic [1:0] SPI_MODE_1 = 2'd1;
   localparam logic [1:0] SPI_MODE_2 = 2'd2;
   localparam logic [1:0] SPI_MODE_3 = 2'd3;
   localparam logic       MSB_FIRST  = 1'b0;
   localparam logic       LSB_FIRST  = 1'b1;
   // index with no register behind it; the block must ignore it
   localparam logic [1:0] CSR_SPARE  = 2'd3;

   logic       clock = 1'b0;
   logic       reset;

   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_action;
   logic [7:0] req_tx_byte;
   logic       req_miso_bit;

   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_sck_level;
   logic       rsp_mosi_level;
   logic [7:0] rsp_rx_byte;
   logic       rsp_tx_empty;
   logic       rsp_transfer_end;
   logic       rsp_rx_full;
   logic       rsp_overrun;

   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_data;

   int req_idle_pct;
   int rsp_idle_pct;
   logic hold_toggle;
   logic hold_seen;
   int hold_left;
   int words_sent;
   int settings_count;
   int cur_divisor;
   int cycle_count = 0;

   int mismatch_count;
   int words_pending;
   int bytes_shifted;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   spi_master_byte_shifter #(
      .PRESCALE(SPI_PRESCALE)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_tx_byte      (req_tx_byte),
      .req_miso_bit     (req_miso_bit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sck_level    (rsp_sck_level),
      .rsp_mosi_level   (rsp_mosi_level),
      .rsp_rx_byte      (rsp_rx_byte),
      .rsp_tx_empty     (rsp_tx_empty),
      .rsp_transfer_end (rsp_transfer_end),
      .rsp_rx_full      (rsp_rx_full),
      .rsp_overrun      (rsp_overrun),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   spi_shifter_checker #(
      .PRESCALE(SPI_PRESCALE)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_tx_byte      (req_tx_byte),
      .req_miso_bit     (req_miso_bit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sck_level    (rsp_sck_level),
      .rsp_mosi_level   (rsp_mosi_level),
      .rsp_rx_byte      (rsp_rx_byte),
      .rsp_tx_empty     (rsp_tx_empty),
      .rsp_transfer_end (rsp_transfer_end),
      .rsp_rx_full      (rsp_rx_full),
      .rsp_overrun      (rsp_overrun),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .words_pending    (words_pending),
      .bytes_shifted    (bytes_shifted)
   );

   // Give up on a hung run: the slowest correct run stays far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, words_pending);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response side: drop ready at random per the current idle rate, and hold it
   // low for a long stretch whenever the stimulus flips hold_toggle.
   initial begin
      rsp_ready = 1'b0;
      hold_seen = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   task automatic set_idle(input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct <= rsp_pct;
   endtask

   // Offer one request word, starting and ending at a falling edge. Valid stays
   // high after acceptance so back-to-back words need no second assignment.
   task automatic send_word(input logic [1:0] act, input logic [7:0] data, input logic miso);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_tx_byte  <= data;
      req_miso_bit <= miso;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_random(input logic [1:0] act);
      send_word(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   // Drop valid and hold off until every response word is back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (words_pending != 0);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [7:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= data;
      @(negedge clock);
   endtask

   // Reprogram all registers with the block drained. Unused upper data bits get
   // random values; the block must mask them.
   task automatic program_csr(input logic [1:0] mode, input logic order,
                              input logic [7:0] divisor, input logic spare);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      write_csr(CSR_CLOCK_MODE, {6'($urandom_range(0, 63)), mode});
      write_csr(CSR_LSB_FIRST, {7'($urandom_range(0, 127)), order});
      write_csr(CSR_BAUD_DIVISOR, divisor);
      if (spare)
         write_csr(CSR_SPARE, 8'($urandom_range(0, 255)));
      csr_write_enable <= 1'b0;
      cur_divisor = divisor;
      settings_count++;
   endtask

   // One well-formed byte transfer: load the holding register, tick through all
   // eight bits plus a little, then usually read the byte. Sometimes refill the
   // holding register midway for a back-to-back transfer, and sprinkle in stray
   // bus accesses. Skipped reads let the next byte overrun.
   task automatic run_transfer();
      int span;
      int midpoint;
      span     = SPI_PRESCALE * (cur_divisor + 1) * BITS_PER_WORD + $urandom_range(0, 3);
      midpoint = ($urandom_range(0, 99) < 40) ? $urandom_range(1, span - 1) : -1;
      send_random(ACT_WRITE);
      for (int i = 0; i < span; i++) begin
         if (i == midpoint)
            send_random(ACT_WRITE);
         if ($urandom_range(0, 199) == 0)
            send_random(2'($urandom_range(ACT_WRITE, ACT_CLEAR)));
         send_random(ACT_TICK);
      end
      if ($urandom_range(0, 3) != 0)
         send_random(ACT_READ);
      if ($urandom_range(0, 4) == 0)
         send_random(ACT_CLEAR);
   endtask

   // Mostly transfers, the rest short bursts of arbitrary words.
   task automatic run_traffic(input int count);
      int start;
      int burst;
      start = words_sent;
      while (words_sent - start < count) begin
         if ($urandom_range(0, 99) < 75) begin
            run_transfer();
         end else begin
            burst = $urandom_range(1, 6);
            repeat (burst) send_random(2'($urandom_range(ACT_TICK, ACT_CLEAR)));
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = ACT_TICK;
      req_tx_byte      = '0;
      req_miso_bit     = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_CLOCK_MODE;
      csr_data         = '0;
      hold_toggle      = 1'b0;
      req_idle_pct     = 0;
      rsp_idle_pct     = 0;
      words_sent       = 0;
      settings_count   = 0;
      cur_divisor      = BAUD_DIVISOR_RESET;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase 1: sender idles lightly, receiver heavily.
      set_idle(19, 60);
      program_csr(SPI_MODE_0, MSB_FIRST, 8'd0, 1'b0);

      // Directed: read and clear with nothing pending, an idle tick, overwrite a
      // full holding register, field extremes, then bus accesses mid-transfer.
      send_word(ACT_READ,  8'h00, 1'b0);
      send_word(ACT_CLEAR, 8'hFF, 1'b1);
      send_word(ACT_TICK,  8'h00, 1'b1);
      send_word(ACT_WRITE, 8'hFF, 1'b0);
      send_word(ACT_WRITE, 8'h00, 1'b1);
      send_word(ACT_WRITE, 8'hC3, 1'b0);
      for (int i = 0; i < 12; i++)
         send_word(ACT_TICK, 8'hFF, 1'(i % 2));
      send_word(ACT_READ,  8'h5A, 1'b1);
      send_word(ACT_CLEAR, 8'hA5, 1'b0);
      send_word(ACT_WRITE, 8'h3C, 1'b1);
      for (int i = 0; i < 3; i++)
         send_word(ACT_TICK, 8'h00, 1'b1);

      run_traffic(250);
      // pause the sender until every response word is back, then carry on
      wait_drained();
      run_traffic(100);

      // Phase 2: the other way round, LSB first, slower clock, spare index written.
      set_idle(60, 19);
      program_csr(SPI_MODE_3, LSB_FIRST, 8'd1, 1'b1);
      run_traffic(200);

      // Phase 3: no idling. Hold the receiver off for a long stretch while the
      // sender keeps offering words, so the block fills up and stalls its input.
      set_idle(0, 0);
      program_csr(SPI_MODE_1, MSB_FIRST, 8'd0, 1'b0);
      hold_toggle <= ~hold_toggle;
      run_traffic(120);
      program_csr(SPI_MODE_2, LSB_FIRST, 8'd2, 1'b0);
      run_traffic(150);

      // Switch to the slowest clock, possibly under a running transfer, load a
      // byte and tick a while under the longest half period.
      program_csr(SPI_MODE_2, MSB_FIRST, 8'd255, 1'b0);
      send_random(ACT_WRITE);
      repeat (SLOW_TICKS) send_random(ACT_TICK);
      send_random(ACT_READ);

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Ran %0d request words under %0d register settings (all modes, both bit orders,",
               words_sent, settings_count);
      $display("divisors 0 to 255), with %0d bytes shifted; %0d mismatches.",
               bytes_shifted, mismatch_count);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
